### sv/ssr_pkg.sv
// ssr_pkg: shared types and constants of the servo sweep ramp.
// Used by servo_sweep_ramp and its checker; depends on nothing.
`default_nettype none

package ssr_pkg;

    localparam int ANGLE_W  = 8;
    localparam int PULSE_W  = 15;
    localparam int SPEED_W  = 4;
    localparam int DELAY_W  = 7;
    localparam int CFG_ADDR_W = 1;

    // Register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_PULSE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_PULSE = 1'b1;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 15'd500;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 15'd2500;
    localparam logic [DELAY_W-1:0] DELAY_RST     = 7'd100;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LO = -8'sd90;
    localparam logic signed [ANGLE_W-1:0] ANGLE_HI = 8'sd90;
    localparam logic [SPEED_W-1:0] SPEED_MIN   = 4'd1;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 4'd10;
    localparam logic [SPEED_W-1:0] SPEED_LIMIT = 4'd11;

    localparam logic [PULSE_W-1:0] FIELD_MAX = 15'h7FFF;

    // Offset angle (0..180) times |max - min| fits 23 bits
    localparam int MAG_W = 23;
    // x / 180 == (x * DIV180_MUL) >> DIV180_SH, exact for x < 2**MAG_W
    localparam int DIV180_SH = 31;
    localparam longint unsigned DIV180_MUL64 = ((64'd1 << DIV180_SH) + 64'd179) / 64'd180;
    localparam int DIV180_W = 24;
    localparam logic [DIV180_W-1:0] DIV180_MUL = DIV180_W'(DIV180_MUL64);

    // Shift applied after the duty reciprocal multiply
    localparam int DUTY_SH = 31;

endpackage

`default_nettype wire

### sv/servo_sweep_ramp.sv
// servo_sweep_ramp: servo sweep sequencer with pulse width and PWM duty pipeline.
// Depends on ssr_pkg.
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_        in   tvalid/tready      tuser: req_type; tdata: start, end, speed
// m_        out  tvalid/tready      tdata: angle_now, pulse_us, duty; tlast: last
// cfg_      in   cfg_wr_en          cfg_addr selects the register, cfg_wdata value
//
// One item is taken per cycle while s_tready is high. The sweep state (angle,
// delay count) updates in the accept cycle; an item that yields a result then
// runs through stage 1 (clamp, offset) and three multiply stages (offset*span,
// reciprocal of 180, duty reciprocal) into the output register. Each stage moves
// when the stage after it is empty or moving, so a stalled m_ side fills bubbles
// before s_tready drops.
// Reset (aresetn low, synchronous) empties the pipeline, idles the sweep and
// loads 500/2500 us into the pulse registers.

module servo_sweep_ramp #(
    parameter int DUTY_BITS = 14,
    parameter int PERIOD_US = 20000
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    // configuration
    input  wire                             cfg_wr_en,
    input  wire  [ssr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire  [ssr_pkg::PULSE_W-1:0]     cfg_wdata,
    // input items
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [23:0]                     s_tdata,   // from_angle, to_angle, speed
    input  wire                             s_tuser,   // req_type
    // result items
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [39:0]                     m_tdata,   // angle_now, pulse_us, duty
    output logic                            m_tlast    // last
);
    import ssr_pkg::*;

    localparam longint unsigned DUTY_MUL64 =
        ((64'd1 << (DUTY_SH + DUTY_BITS)) + 64'(PERIOD_US) - 64'd1) / 64'(PERIOD_US);
    localparam int DUTY_MUL_W = $clog2(DUTY_MUL64 + 64'd1);
    localparam int DUTY_PROD_W = PULSE_W + DUTY_MUL_W;
    localparam int DUTY_Q_W = DUTY_PROD_W - DUTY_SH;
    localparam logic [DUTY_MUL_W-1:0] DUTY_MUL = DUTY_MUL_W'(DUTY_MUL64);

    // ---------------- configuration registers ----------------
    logic [PULSE_W-1:0] min_pulse_reg, max_pulse_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pulse_reg <= MIN_PULSE_RST;
            max_pulse_reg <= MAX_PULSE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_MIN_PULSE: min_pulse_reg <= cfg_wdata;
                CFG_MAX_PULSE: max_pulse_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- sweep state ----------------
    logic signed [ANGLE_W-1:0] cur_reg, cur_next;
    logic signed [ANGLE_W-1:0] tgt_reg, tgt_next;
    logic                      down_reg, down_next;
    logic [DELAY_W-1:0]        reload_reg, reload_next;
    logic [DELAY_W-1:0]        left_reg, left_next;
    logic                      moving_reg, moving_next;
    logic                      emit;

    logic                      s_fire;
    logic signed [ANGLE_W-1:0] in_start, in_end;
    logic [SPEED_W-1:0]        in_speed, sp_clamped, sp_gap;

    assign in_start = s_tdata[7:0];
    assign in_end   = s_tdata[15:8];
    assign in_speed = s_tdata[19:16];
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        cur_next    = cur_reg;
        tgt_next    = tgt_reg;
        down_next   = down_reg;
        reload_next = reload_reg;
        left_next   = left_reg;
        moving_next = moving_reg;
        emit        = 1'b0;

        if (in_speed < SPEED_MIN)      sp_clamped = SPEED_MIN;
        else if (in_speed > SPEED_MAX) sp_clamped = SPEED_MAX;
        else                           sp_clamped = in_speed;
        sp_gap = SPEED_LIMIT - sp_clamped;

        if (s_fire) begin
            if (!s_tuser) begin
                // move command: restart the sweep, show the start angle now
                cur_next    = in_start;
                tgt_next    = in_end;
                down_next   = !(in_start < in_end);
                reload_next = DELAY_W'({sp_gap, 3'b000}) + DELAY_W'({sp_gap, 1'b0});
                left_next   = reload_next;
                moving_next = 1'b1;
                emit        = 1'b1;
            end else if (moving_reg) begin
                if (left_reg > DELAY_W'(1)) begin
                    left_next = left_reg - DELAY_W'(1);
                end else if (cur_reg == tgt_reg) begin
                    // final angle has dwelt its delay: go idle
                    left_next   = '0;
                    moving_next = 1'b0;
                end else begin
                    cur_next  = down_reg ? cur_reg - ANGLE_W'(1) : cur_reg + ANGLE_W'(1);
                    left_next = reload_reg;
                    emit      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg    <= '0;
            tgt_reg    <= '0;
            down_reg   <= 1'b0;
            reload_reg <= DELAY_RST;
            left_reg   <= '0;
            moving_reg <= 1'b0;
        end else begin
            cur_reg    <= cur_next;
            tgt_reg    <= tgt_next;
            down_reg   <= down_next;
            reload_reg <= reload_next;
            left_reg   <= left_next;
            moving_reg <= moving_next;
        end
    end

    // ---------------- pipeline control ----------------
    logic st1_v_reg, st2_v_reg, st3_v_reg, out_v_reg;
    logic st1_mv, st2_mv, st3_mv, out_ld;

    assign out_ld   = !out_v_reg || m_tready;
    assign st3_mv   = !st3_v_reg || out_ld;
    assign st2_mv   = !st2_v_reg || st3_mv;
    assign st1_mv   = !st1_v_reg || st2_mv;
    assign s_tready = st1_mv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_v_reg <= 1'b0;
            st2_v_reg <= 1'b0;
            st3_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (st1_mv) st1_v_reg <= emit;
            if (st2_mv) st2_v_reg <= st1_v_reg;
            if (st3_mv) st3_v_reg <= st2_v_reg;
            if (out_ld) out_v_reg <= st3_v_reg;
        end
    end

    // ---------------- stage 1: clamp and offset angle ----------------
    logic signed [ANGLE_W-1:0] ang_clamp;
    logic [ANGLE_W-1:0]        aoff_next;
    logic signed [ANGLE_W-1:0] st1_ang_reg;
    logic                      st1_last_reg;
    logic [ANGLE_W-1:0]        st1_aoff_reg;

    always_comb begin
        if (cur_next < ANGLE_LO)      ang_clamp = ANGLE_LO;
        else if (cur_next > ANGLE_HI) ang_clamp = ANGLE_HI;
        else                          ang_clamp = cur_next;
        aoff_next = ANGLE_W'(ang_clamp - ANGLE_LO);
    end

    always_ff @(posedge aclk) begin
        if (st1_mv) begin
            st1_ang_reg  <= cur_next;
            st1_last_reg <= (cur_next == tgt_next);
            st1_aoff_reg <= aoff_next;
        end
    end

    // ---------------- stage 2: offset times pulse span ----------------
    logic signed [PULSE_W:0] span;
    logic                    span_neg;
    logic [PULSE_W-1:0]      span_mag;
    logic signed [ANGLE_W-1:0] st2_ang_reg;
    logic                    st2_last_reg, st2_neg_reg;
    logic [MAG_W-1:0]        st2_mag_reg;

    always_comb begin
        span     = $signed({1'b0, max_pulse_reg}) - $signed({1'b0, min_pulse_reg});
        span_neg = span[PULSE_W];
        span_mag = span_neg ? PULSE_W'(-span) : PULSE_W'(span);
    end

    always_ff @(posedge aclk) begin
        if (st2_mv) begin
            st2_ang_reg  <= st1_ang_reg;
            st2_last_reg <= st1_last_reg;
            st2_neg_reg  <= span_neg;
            st2_mag_reg  <= MAG_W'(st1_aoff_reg) * MAG_W'(span_mag);
        end
    end

    // ---------------- stage 3: divide by 180, add minimum ----------------
    localparam int Q180_W = MAG_W + DIV180_W;
    logic [Q180_W-1:0]       q180_prod;
    logic [PULSE_W-1:0]      q180;
    logic [PULSE_W+1:0]      pulse_sum;
    logic signed [ANGLE_W-1:0] st3_ang_reg;
    logic                    st3_last_reg;
    logic [PULSE_W-1:0]      st3_pulse_reg;

    always_comb begin
        q180_prod = Q180_W'(st2_mag_reg) * Q180_W'(DIV180_MUL);
        q180      = PULSE_W'(q180_prod >> DIV180_SH);
        // truncation toward zero: divide the magnitude, then reapply the sign
        pulse_sum = st2_neg_reg ? ({2'b00, min_pulse_reg} - {2'b00, q180})
                                : ({2'b00, min_pulse_reg} + {2'b00, q180});
    end

    always_ff @(posedge aclk) begin
        if (st3_mv) begin
            st3_ang_reg   <= st2_ang_reg;
            st3_last_reg  <= st2_last_reg;
            st3_pulse_reg <= PULSE_W'(pulse_sum);
        end
    end

    // ---------------- output stage: duty ----------------
    logic [DUTY_PROD_W-1:0]  duty_prod;
    logic [DUTY_Q_W-1:0]     duty_q;
    logic [PULSE_W-1:0]      duty_sat;
    logic signed [ANGLE_W-1:0] out_ang_reg;
    logic                    out_last_reg;
    logic [PULSE_W-1:0]      out_pulse_reg, out_duty_reg;

    always_comb begin
        duty_prod = DUTY_PROD_W'(st3_pulse_reg) * DUTY_PROD_W'(DUTY_MUL);
        duty_q    = DUTY_Q_W'(duty_prod >> DUTY_SH);
        // saturate at the field maximum
        if (64'(duty_q) > 64'(FIELD_MAX)) duty_sat = FIELD_MAX;
        else                              duty_sat = PULSE_W'(duty_q);
    end

    always_ff @(posedge aclk) begin
        if (out_ld) begin
            out_ang_reg   <= st3_ang_reg;
            out_last_reg  <= st3_last_reg;
            out_pulse_reg <= st3_pulse_reg;
            out_duty_reg  <= duty_sat;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_duty_reg, out_pulse_reg, out_ang_reg};

endmodule

`default_nettype wire

### sv/ssr_checker.sv
// ssr_checker: port-level checks for servo_sweep_ramp, bound to the top level.
// Depends on ssr_pkg and servo_sweep_ramp.
`default_nettype none

module ssr_checker #(
    parameter int DUTY_BITS = 14,
    parameter int PERIOD_US = 20000
) (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_tready,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [39:0]                     m_tdata,   // angle_now, pulse_us, duty
    input wire                            m_tlast    // last
);
    import ssr_pkg::*;

    logic [63:0] pulse_scaled, duty_lo, duty_hi;

    assign pulse_scaled = 64'(m_tdata[22:8]) << DUTY_BITS;
    assign duty_lo      = 64'(m_tdata[37:23]) * 64'(PERIOD_US);
    assign duty_hi      = duty_lo + 64'(PERIOD_US);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Drop all results on reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // An empty output never blocks the input side
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Duty is the truncated quotient of pulse scaled by the period, or saturated
    a_duty_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (duty_lo <= pulse_scaled) &&
                     ((duty_hi > pulse_scaled) || (m_tdata[37:23] == FIELD_MAX)))
        else $error("duty does not match pulse width");

endmodule

bind servo_sweep_ramp ssr_checker #(
    .DUTY_BITS(DUTY_BITS),
    .PERIOD_US(PERIOD_US)
) u_ssr_checker (.*);

`default_nettype wire
